// ===== hw/rtl/i2crm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2crm_pkg: shared types and constants of the I2C register master
// Item codes, operation codes, sequencer phases, queue sizing, the request
// record passed from the front end to the sequencer and the result record.
// ---------------------------------------------------------------------------
package i2crm_pkg;

  // Raw request kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_TICK    = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START1  = 5'd1,
    PH_AW_BITS = 5'd2,
    PH_AW_ACK  = 5'd3,
    PH_RH_BITS = 5'd4,
    PH_RH_ACK  = 5'd5,
    PH_RL_BITS = 5'd6,
    PH_RL_ACK  = 5'd7,
    PH_START2  = 5'd8,
    PH_AR_BITS = 5'd9,
    PH_AR_ACK  = 5'd10,
    PH_DW_BITS = 5'd11,
    PH_DW_ACK  = 5'd12,
    PH_PR_BITS = 5'd13,
    PH_PR_ACK  = 5'd14,
    PH_RX_BITS = 5'd15,
    PH_RX_ACK  = 5'd16,
    PH_STOP    = 5'd17
  } phase_t;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'h3a;
  localparam logic [2:0] NACK_MAX         = 3'd7;

  // Request queue between front end and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Classified request; byte_count already has zero mapped to one
  typedef struct packed {
    item_kind_t  kind;
    logic        sda_sample;
    op_t         operation;
    logic        wide_register;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       write_wanted;
    logic       done_res;
    logic [2:0] nack_count;
  } result_t;

endpackage

// ===== hw/rtl/i2crm_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2crm_if: request and result channels of the I2C register master
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface i2crm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        sda_sample;
  logic [1:0]  operation;
  logic        wide_register;
  logic [15:0] register_address;
  logic [7:0]  byte_count;
  logic [7:0]  data_byte;

  modport source (
    output valid, kind, sda_sample, operation, wide_register,
           register_address, byte_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, sda_sample, operation, wide_register,
           register_address, byte_count, data_byte,
    output ready
  );
endinterface

interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_released;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       read_last;
  logic       write_wanted;
  logic       done_res;
  logic [2:0] nack_count;

  modport source (
    output valid, scl_level, sda_level, sda_released, read_valid, read_byte,
           read_last, write_wanted, done_res, nack_count,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_released, read_valid, read_byte,
           read_last, write_wanted, done_res, nack_count,
    output ready
  );
endinterface

// ===== hw/rtl/i2crm_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2crm_front: request intake and classification
// Accept requests while the queue has room, drop unused kinds and operation
// codes, and normalize the byte count before queueing.
// ---------------------------------------------------------------------------
module i2crm_front (
  i2crm_in_if.sink          in_chan,
  input  logic              q_full,
  output logic              q_push,
  output i2crm_pkg::item_t  q_push_item
);

  logic keep;

  assign in_chan.ready = !q_full;

  // Drop unused kinds and commands with an unknown operation code
  always_comb begin
    keep = 1'b0;
    unique case (in_chan.kind)
      i2crm_pkg::KIND_COMMAND: keep = (in_chan.operation != 2'd3);
      i2crm_pkg::KIND_DATA:    keep = 1'b1;
      i2crm_pkg::KIND_TICK:    keep = 1'b1;
      default:                 keep = 1'b0;
    endcase
  end

  assign q_push = in_chan.valid && in_chan.ready && keep;

  always_comb begin
    q_push_item.kind             = i2crm_pkg::item_kind_t'(in_chan.kind);
    q_push_item.sda_sample       = in_chan.sda_sample;
    q_push_item.operation        = i2crm_pkg::op_t'(in_chan.operation);
    q_push_item.wide_register    = in_chan.wide_register;
    q_push_item.register_address = in_chan.register_address;
    q_push_item.byte_count       = (in_chan.byte_count == 8'd0) ? 8'd1 : in_chan.byte_count;
    q_push_item.data_byte        = in_chan.data_byte;
  end

endmodule

// ===== hw/rtl/i2crm_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2crm_queue: short request queue
// Small FIFO that decouples request intake from the bus sequencer.
// ---------------------------------------------------------------------------
module i2crm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2crm_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output i2crm_pkg::item_t  pop_item,
  output logic              empty
);

  i2crm_pkg::item_t                     entries_r [i2crm_pkg::QUEUE_DEPTH];
  logic [i2crm_pkg::QUEUE_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2crm_pkg::QUEUE_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2crm_pkg::QUEUE_CW-1:0]       count_r, count_nxt;

  localparam logic [i2crm_pkg::QUEUE_AW-1:0] LastIdx =
    i2crm_pkg::QUEUE_AW'(i2crm_pkg::QUEUE_DEPTH - 1);
  localparam logic [i2crm_pkg::QUEUE_CW-1:0] FullCount =
    i2crm_pkg::QUEUE_CW'(i2crm_pkg::QUEUE_DEPTH);

  assign full     = (count_r == FullCount);
  assign empty    = (count_r == '0);
  assign pop_item = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/i2crm_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2crm_seq: bus phase sequencer
// Pop queued requests, step the SCL/SDA phases one tick at a time and hold
// each tick's result in an output register until it is taken.
// ---------------------------------------------------------------------------
module i2crm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              q_empty,
  input  i2crm_pkg::item_t  q_item,
  output logic              q_pop,
  i2crm_out_if.source       out_chan
);

  i2crm_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [15:0]       reg_addr_r, reg_addr_nxt;
  i2crm_pkg::op_t    op_r, op_nxt;
  logic              wide_r, wide_nxt;
  logic [8:0]        pending_r, pending_nxt;
  logic [2:0]        nack_r, nack_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              rel_r, rel_nxt;
  logic [7:0]        slave_r;

  logic              out_valid_r, out_valid_nxt;
  i2crm_pkg::result_t res_r, res_nxt;

  logic              slot_free;
  logic              tick;
  logic [7:0]        shift_cur;
  logic [7:0]        shift_in;
  logic              rv, rl, ww, dn;
  logic [7:0]        rb;
  logic              last_byte;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign q_pop     = !q_empty && ((q_item.kind != i2crm_pkg::KIND_TICK) || slot_free);
  assign tick      = q_pop && (q_item.kind == i2crm_pkg::KIND_TICK);
  assign last_byte = (left_r <= 8'd1);
  assign shift_in  = {shift_r[6:0], q_item.sda_sample};

  always_comb begin
    phase_nxt    = phase_r;
    sub_nxt      = sub_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    left_nxt     = left_r;
    reg_addr_nxt = reg_addr_r;
    op_nxt       = op_r;
    wide_nxt     = wide_r;
    pending_nxt  = pending_r;
    nack_nxt     = nack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    rel_nxt      = rel_r;
    shift_cur    = shift_r;
    rv = 1'b0;
    rb = 8'd0;
    rl = 1'b0;
    ww = 1'b0;
    dn = 1'b0;

    if (q_pop && (q_item.kind == i2crm_pkg::KIND_COMMAND) &&
        (phase_r == i2crm_pkg::PH_IDLE)) begin
      op_nxt       = q_item.operation;
      wide_nxt     = q_item.wide_register;
      reg_addr_nxt = q_item.register_address;
      left_nxt     = q_item.byte_count;
      nack_nxt     = 3'd0;
      shift_nxt    = q_item.data_byte;
      phase_nxt    = i2crm_pkg::PH_START1;
      sub_nxt      = 2'd0;
      bit_nxt      = 3'd0;
    end

    // A new data byte replaces any byte still waiting
    if (q_pop && (q_item.kind == i2crm_pkg::KIND_DATA)) begin
      pending_nxt = {1'b1, q_item.data_byte};
    end

    if (tick) begin
      unique case (phase_r)
        i2crm_pkg::PH_IDLE: begin
        end

        i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
          rel_nxt = 1'b0;
          unique case (sub_r)
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
          if (sub_r != 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            sub_nxt = 2'd0;
            bit_nxt = 3'd0;
            if (phase_r == i2crm_pkg::PH_START2) begin
              shift_nxt = slave_r + 8'd1;
              phase_nxt = i2crm_pkg::PH_AR_BITS;
            end else if (op_r == i2crm_pkg::OP_PROBE) begin
              phase_nxt = i2crm_pkg::PH_PR_BITS;
            end else begin
              shift_nxt = slave_r;
              phase_nxt = i2crm_pkg::PH_AW_BITS;
            end
          end
        end

        i2crm_pkg::PH_AW_BITS, i2crm_pkg::PH_RH_BITS, i2crm_pkg::PH_RL_BITS,
        i2crm_pkg::PH_AR_BITS, i2crm_pkg::PH_DW_BITS, i2crm_pkg::PH_PR_BITS: begin
          // Data bytes start only once a write byte is waiting
          if ((phase_r == i2crm_pkg::PH_DW_BITS) && (sub_r == 2'd0) && (bit_r == 3'd0)) begin
            if (!pending_r[8]) begin
              ww = 1'b1;
            end else begin
              shift_cur   = pending_r[7:0];
              pending_nxt = 9'd0;
            end
          end
          if (!ww) begin
            shift_nxt = shift_cur;
            unique case (sub_r)
              2'd0: begin
                rel_nxt = 1'b0;
                sda_nxt = shift_cur[~bit_r];
                sub_nxt = 2'd1;
              end
              2'd1: begin
                scl_nxt = 1'b1;
                sub_nxt = 2'd2;
              end
              default: begin
                scl_nxt = 1'b0;
                sub_nxt = 2'd0;
                if (bit_r == 3'd7) begin
                  bit_nxt = 3'd0;
                  unique case (phase_r)
                    i2crm_pkg::PH_AW_BITS: phase_nxt = i2crm_pkg::PH_AW_ACK;
                    i2crm_pkg::PH_RH_BITS: phase_nxt = i2crm_pkg::PH_RH_ACK;
                    i2crm_pkg::PH_RL_BITS: phase_nxt = i2crm_pkg::PH_RL_ACK;
                    i2crm_pkg::PH_AR_BITS: phase_nxt = i2crm_pkg::PH_AR_ACK;
                    i2crm_pkg::PH_DW_BITS: phase_nxt = i2crm_pkg::PH_DW_ACK;
                    default:               phase_nxt = i2crm_pkg::PH_PR_ACK;
                  endcase
                end else begin
                  bit_nxt = bit_r + 3'd1;
                end
              end
            endcase
          end
        end

        i2crm_pkg::PH_AW_ACK, i2crm_pkg::PH_RH_ACK, i2crm_pkg::PH_RL_ACK,
        i2crm_pkg::PH_AR_ACK, i2crm_pkg::PH_DW_ACK, i2crm_pkg::PH_PR_ACK: begin
          rel_nxt = 1'b1;
          if (sub_r == 2'd1) begin
            scl_nxt = 1'b1;
          end
          if ((sub_r == 2'd2) && q_item.sda_sample && (nack_r != i2crm_pkg::NACK_MAX)) begin
            nack_nxt = nack_r + 3'd1;
          end
          if (sub_r != 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            scl_nxt = 1'b0;
            sub_nxt = 2'd0;
            bit_nxt = 3'd0;
            unique case (phase_r)
              i2crm_pkg::PH_AW_ACK: begin
                if (wide_r) begin
                  shift_nxt = reg_addr_r[15:8];
                  phase_nxt = i2crm_pkg::PH_RH_BITS;
                end else begin
                  shift_nxt = reg_addr_r[7:0];
                  phase_nxt = i2crm_pkg::PH_RL_BITS;
                end
              end
              i2crm_pkg::PH_RH_ACK: begin
                shift_nxt = reg_addr_r[7:0];
                phase_nxt = i2crm_pkg::PH_RL_BITS;
              end
              i2crm_pkg::PH_RL_ACK: begin
                priority if (op_r == i2crm_pkg::OP_READ) begin
                  phase_nxt = i2crm_pkg::PH_START2;
                end else if (nack_r != 3'd0) begin
                  phase_nxt = i2crm_pkg::PH_STOP;
                end else begin
                  phase_nxt = i2crm_pkg::PH_DW_BITS;
                end
              end
              i2crm_pkg::PH_AR_ACK: begin
                // After any NACK, read one last byte only
                if (nack_r != 3'd0) begin
                  left_nxt = 8'd1;
                end
                phase_nxt = i2crm_pkg::PH_RX_BITS;
              end
              i2crm_pkg::PH_DW_ACK: begin
                if ((nack_r != 3'd0) || last_byte) begin
                  phase_nxt = i2crm_pkg::PH_STOP;
                end else begin
                  left_nxt  = left_r - 8'd1;
                  phase_nxt = i2crm_pkg::PH_DW_BITS;
                end
              end
              default: phase_nxt = i2crm_pkg::PH_STOP;
            endcase
          end
        end

        i2crm_pkg::PH_RX_BITS: begin
          rel_nxt = 1'b1;
          unique case (sub_r)
            2'd0: begin
              scl_nxt = 1'b1;
              sub_nxt = 2'd1;
            end
            2'd1: begin
              shift_nxt = shift_in;
              if (bit_r == 3'd7) begin
                rv = 1'b1;
                rb = shift_in;
                rl = last_byte;
              end
              sub_nxt = 2'd2;
            end
            default: begin
              scl_nxt = 1'b0;
              sub_nxt = 2'd0;
              if (bit_r == 3'd7) begin
                bit_nxt   = 3'd0;
                phase_nxt = i2crm_pkg::PH_RX_ACK;
              end else begin
                bit_nxt = bit_r + 3'd1;
              end
            end
          endcase
        end

        i2crm_pkg::PH_RX_ACK: begin
          rel_nxt = 1'b0;
          if (sub_r == 2'd0) begin
            sda_nxt = last_byte;
            scl_nxt = 1'b1;
            sub_nxt = 2'd1;
          end else begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
            sub_nxt = 2'd0;
            bit_nxt = 3'd0;
            if (last_byte) begin
              phase_nxt = i2crm_pkg::PH_STOP;
            end else begin
              left_nxt  = left_r - 8'd1;
              phase_nxt = i2crm_pkg::PH_RX_BITS;
            end
          end
        end

        // STOP, and any code outside the phase list
        default: begin
          rel_nxt = 1'b0;
          unique case (sub_r)
            2'd0: begin
              sda_nxt = 1'b0;
              sub_nxt = 2'd1;
            end
            2'd1: begin
              scl_nxt = 1'b1;
              sub_nxt = 2'd2;
            end
            default: begin
              sda_nxt   = 1'b1;
              dn        = 1'b1;
              phase_nxt = i2crm_pkg::PH_IDLE;
              sub_nxt   = 2'd0;
              bit_nxt   = 3'd0;
            end
          endcase
        end
      endcase
    end

    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_level    = sda_nxt;
    res_nxt.sda_released = rel_nxt;
    res_nxt.read_valid   = rv;
    res_nxt.read_byte    = rb;
    res_nxt.read_last    = rl;
    res_nxt.write_wanted = ww;
    res_nxt.done_res     = dn;
    res_nxt.nack_count   = nack_nxt;

    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2crm_pkg::PH_IDLE;
      sub_r       <= 2'd0;
      bit_r       <= 3'd0;
      shift_r     <= 8'd0;
      left_r      <= 8'd0;
      reg_addr_r  <= 16'd0;
      op_r        <= i2crm_pkg::OP_PROBE;
      wide_r      <= 1'b0;
      pending_r   <= 9'd0;
      nack_r      <= 3'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      rel_r       <= 1'b0;
      slave_r     <= i2crm_pkg::SLAVE_ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      left_r      <= left_nxt;
      reg_addr_r  <= reg_addr_nxt;
      op_r        <= op_nxt;
      wide_r      <= wide_nxt;
      pending_r   <= pending_nxt;
      nack_r      <= nack_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        slave_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.scl_level    = res_r.scl_level;
  assign out_chan.sda_level    = res_r.sda_level;
  assign out_chan.sda_released = res_r.sda_released;
  assign out_chan.read_valid   = res_r.read_valid;
  assign out_chan.read_byte    = res_r.read_byte;
  assign out_chan.read_last    = res_r.read_last;
  assign out_chan.write_wanted = res_r.write_wanted;
  assign out_chan.done_res     = res_r.done_res;
  assign out_chan.nack_count   = res_r.nack_count;

  // Idle bus always has SCL and SDA driven high
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2crm_pkg::PH_IDLE) |-> (scl_r && sda_r && !rel_r))
    else $error("bus not high while idle");

  // A finished STOP returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && dn) |=> (phase_r == i2crm_pkg::PH_IDLE))
    else $error("done without return to idle");

  // A received byte completes only on the sample of its last bit
  a_read_point: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && rv) |-> ((phase_r == i2crm_pkg::PH_RX_BITS) && (sub_r == 2'd1) &&
                      (bit_r == 3'd7)))
    else $error("read byte outside last bit sample");

  // No transaction sees more than four NACKs
  a_nack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nack_r <= 3'd4)
    else $error("NACK count beyond transaction bound");

  // A stalled tick leaves the sequencer where it was
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && ww) |=> ((phase_r == i2crm_pkg::PH_DW_BITS) && (sub_r == 2'd0) &&
                      (bit_r == 3'd0) && $stable(scl_r)))
    else $error("write stall moved the sequencer");

endmodule

// ===== hw/rtl/i2c_register_master.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_register_master: I2C register read/write master, tick driven
// Front end, request queue and bus phase sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries requests: a command (probe, register write, register
//   read), a write data byte, or a bus tick with the sampled SDA level.
//   Each tick stands for one phase delay and yields exactly one result on
//   out_chan: the SCL/SDA levels to drive, SDA direction, any received byte,
//   the write-byte stall flag, the done flag and the NACK count. Commands and
//   data bytes produce no result; unknown kinds and operation codes are
//   accepted and dropped.
//   cfg_we/cfg_wdata set the 8-bit target write address (read uses +1);
//   write it only while the bus is idle and no request is in flight.
//   Throughput: one request per cycle while out_chan keeps taking results,
//   as the sequencer makes a single phase step per tick. A tick's request
//   is written into the two-entry queue, its result is registered as it
//   leaves the queue and stays in the result register until it is taken.
//   Reset leaves the bus idle with SCL and SDA high and driven, the address
//   at 0x3a and no write byte waiting.
//   If out_chan stalls, the result register holds, the sequencer stops on
//   the next tick and the queue fills; in_chan.ready drops once it is full.
// ---------------------------------------------------------------------------
module i2c_register_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  i2crm_in_if.sink    in_chan,
  i2crm_out_if.source out_chan
);

  logic             q_push;
  i2crm_pkg::item_t q_push_item;
  logic             q_full;
  logic             q_pop;
  i2crm_pkg::item_t q_pop_item;
  logic             q_empty;

  // Classify requests and drop the ones that mean nothing
  i2crm_front u_front (
    .in_chan     (in_chan),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_item (q_push_item)
  );

  // Decouple intake from the sequencer so each side can stall alone
  i2crm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .empty     (q_empty)
  );

  // Advance the bus one phase per tick and register each result
  i2crm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the I2C register master
// Drives commands, write bytes and bus ticks through the request channel and
// checks every per-tick result against a cycle-free model of the bus sequencer
// or a hand-readable script value. A short scripted part comes first, then random
// transactions under several idle/stall patterns and slave addresses.
// ---------------------------------------------------------------------------
module testbench;

  // Codes the package has no name for: the spare request kind and operation
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // SDA level fed on the ticks of a script row
  localparam logic [1:0] SDA_LOW    = 2'd0;
  localparam logic [1:0] SDA_HIGH   = 2'd1;
  localparam logic [1:0] SDA_RANDOM = 2'd2;
  // Repeat count meaning: keep ticking until the bus is back to idle
  localparam logic [7:0] UNTIL_IDLE = 8'd0;

  // Cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 3000;
  // Long receiver hold-off used once to fill the request queue
  localparam int HOLD_OFF     = 300;
  localparam int PHASE_ITEMS  = 200;
  // Result path runs through the queue and the result register; leave some margin
  localparam int SETTLE       = 6;

  // Hand-readable results: idle bus, and START with SDA low, then with SCL low too
  localparam i2crm_pkg::result_t BUS_IDLE   =
    '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0};
  localparam i2crm_pkg::result_t START_HELD =
    '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0};
  localparam i2crm_pkg::result_t START_DONE =
    '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0};
  localparam i2crm_pkg::result_t NO_CHECK   = '0;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sda_sample;
    logic [1:0]  operation;
    logic        wide_register;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         sda_mode;
    logic [1:0]         operation;
    logic               wide;
    logic [15:0]        reg_addr;
    logic [7:0]         count;
    logic [7:0]         data;
    logic [7:0]         reps;
    logic               typed;
    i2crm_pkg::result_t want;
  } script_row_t;

  // Scripted opening: idle ticks, ignored requests, replaced write byte,
  // a full probe with its START checked edge by edge, a wide write with the
  // zero byte count, a write stalling for its bytes, a read with random SDA
  // samples, a NACKed read with the largest count, and a NACKed write.
  script_row_t script [27] = '{
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, BUS_IDLE},
    '{KIND_UNUSED, SDA_HIGH, OP_UNUSED, 1'b1, 16'hffff, 8'hff, 8'hff, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_HIGH,   OP_UNUSED,           1'b1, 16'hffff, 8'hff,
      8'hff, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_HIGH,   i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, BUS_IDLE},
    '{i2crm_pkg::KIND_DATA,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'hff, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_DATA,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'ha5, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_WRITE, 1'b1, 16'h5555, 8'h07,
      8'h3c, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, BUS_IDLE},
    '{i2crm_pkg::KIND_TICK,    SDA_HIGH,   i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, BUS_IDLE},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, START_HELD},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd1, 1'b1, START_DONE},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_WRITE, 1'b1, 16'hffff, 8'h00,
      8'h5a, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_WRITE, 1'b0, 16'h0000, 8'h02,
      8'h00, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd63, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_DATA,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h80, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, 8'd30, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_DATA,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h7f, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_LOW,    i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_READ,  1'b0, 16'h00ff, 8'h02,
      8'h00, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_RANDOM, i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_READ,  1'b1, 16'h8001, 8'hff,
      8'h00, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_HIGH,   i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_COMMAND, SDA_LOW,    i2crm_pkg::OP_WRITE, 1'b1, 16'h1234, 8'h03,
      8'h00, 8'd1, 1'b0, NO_CHECK},
    '{i2crm_pkg::KIND_TICK,    SDA_HIGH,   i2crm_pkg::OP_PROBE, 1'b0, 16'h0000, 8'h00,
      8'h00, UNTIL_IDLE, 1'b0, NO_CHECK}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2crm_in_if  in_chan ();
  i2crm_out_if out_chan ();

  i2c_register_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Bus sequencer model state
  logic [7:0]        bus_address;
  i2crm_pkg::phase_t bus_phase;
  logic [1:0]        sub_tick;
  logic [2:0]        bit_idx;
  logic [7:0]        shreg;
  logic [7:0]        bytes_left;
  logic [15:0]       saved_reg;
  i2crm_pkg::op_t    saved_op;
  logic              saved_wide;
  logic [8:0]        write_byte_slot;   // bit 8 marks a byte waiting
  logic [2:0]        nack_total;
  logic              scl_pin;
  logic              sda_pin;
  logic              sda_rel;

  i2crm_pkg::result_t results_due [$];

  int accepted_requests;
  int results_checked;
  int mismatches;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $realtime, results_checked, msg);
  endtask

  task automatic enter_phase(input i2crm_pkg::phase_t nxt);
    bus_phase = nxt;
    sub_tick  = 2'd0;
    bit_idx   = 3'd0;
  endtask

  // Advance the bus model by one accepted request; only ticks give a result
  task automatic step_bus_master(input req_t r, output bit has_res,
                                 output i2crm_pkg::result_t res);
    logic sda_shown;
    bit   stalled;
    res     = '0;
    has_res = 1'b0;
    stalled = 1'b0;
    case (r.kind)
      i2crm_pkg::KIND_COMMAND: begin
        if (bus_phase == i2crm_pkg::PH_IDLE && r.operation != OP_UNUSED) begin
          saved_op   = i2crm_pkg::op_t'(r.operation);
          saved_wide = r.wide_register;
          saved_reg  = r.register_address;
          bytes_left = (r.byte_count == 8'd0) ? 8'd1 : r.byte_count;
          nack_total = 3'd0;
          shreg      = r.data_byte;
          enter_phase(i2crm_pkg::PH_START1);
        end
      end
      i2crm_pkg::KIND_DATA: write_byte_slot = {1'b1, r.data_byte};
      i2crm_pkg::KIND_TICK: begin
        has_res   = 1'b1;
        sda_shown = sda_pin;
        case (bus_phase)
          i2crm_pkg::PH_IDLE: ;
          i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
            sda_rel = 1'b0;
            case (sub_tick)
              2'd0: sda_pin = 1'b1;
              2'd1: scl_pin = 1'b1;
              2'd2: sda_pin = 1'b0;
              default: scl_pin = 1'b0;
            endcase
            if (sub_tick != 2'd3) begin
              sub_tick++;
            end else if (bus_phase == i2crm_pkg::PH_START2) begin
              shreg = bus_address + 8'd1;
              enter_phase(i2crm_pkg::PH_AR_BITS);
            end else if (saved_op == i2crm_pkg::OP_PROBE) begin
              enter_phase(i2crm_pkg::PH_PR_BITS);
            end else begin
              shreg = bus_address;
              enter_phase(i2crm_pkg::PH_AW_BITS);
            end
          end
          i2crm_pkg::PH_AW_BITS, i2crm_pkg::PH_RH_BITS, i2crm_pkg::PH_RL_BITS,
          i2crm_pkg::PH_AR_BITS, i2crm_pkg::PH_DW_BITS, i2crm_pkg::PH_PR_BITS: begin
            // A data byte is fetched only at the start of its first bit
            if (bus_phase == i2crm_pkg::PH_DW_BITS && sub_tick == 2'd0 && bit_idx == 3'd0) begin
              if (!write_byte_slot[8]) begin
                stalled = 1'b1;
              end else begin
                shreg           = write_byte_slot[7:0];
                write_byte_slot = '0;
              end
            end
            res.write_wanted = stalled;
            if (!stalled) begin
              if (sub_tick == 2'd0) begin
                sda_rel  = 1'b0;
                sda_pin  = shreg[3'd7 - bit_idx];
                sub_tick = 2'd1;
              end else if (sub_tick == 2'd1) begin
                scl_pin  = 1'b1;
                sub_tick = 2'd2;
              end else begin
                scl_pin  = 1'b0;
                sub_tick = 2'd0;
                if (bit_idx == 3'd7) begin
                  bit_idx   = 3'd0;
                  bus_phase = i2crm_pkg::phase_t'(bus_phase + 5'd1);
                end else begin
                  bit_idx++;
                end
              end
            end
          end
          i2crm_pkg::PH_AW_ACK, i2crm_pkg::PH_RH_ACK, i2crm_pkg::PH_RL_ACK,
          i2crm_pkg::PH_AR_ACK, i2crm_pkg::PH_DW_ACK, i2crm_pkg::PH_PR_ACK: begin
            sda_rel = 1'b1;
            if (sub_tick == 2'd1) scl_pin = 1'b1;
            if (sub_tick == 2'd2 && r.sda_sample && nack_total < i2crm_pkg::NACK_MAX)
              nack_total++;
            if (sub_tick != 2'd3) begin
              sub_tick++;
            end else begin
              scl_pin = 1'b0;
              case (bus_phase)
                i2crm_pkg::PH_AW_ACK: begin
                  shreg = saved_wide ? saved_reg[15:8] : saved_reg[7:0];
                  enter_phase(saved_wide ? i2crm_pkg::PH_RH_BITS : i2crm_pkg::PH_RL_BITS);
                end
                i2crm_pkg::PH_RH_ACK: begin
                  shreg = saved_reg[7:0];
                  enter_phase(i2crm_pkg::PH_RL_BITS);
                end
                i2crm_pkg::PH_RL_ACK: begin
                  if (saved_op == i2crm_pkg::OP_READ) enter_phase(i2crm_pkg::PH_START2);
                  else if (nack_total != 3'd0) enter_phase(i2crm_pkg::PH_STOP);
                  else enter_phase(i2crm_pkg::PH_DW_BITS);
                end
                i2crm_pkg::PH_AR_ACK: begin
                  // Any NACK so far cuts the read down to one last byte
                  if (nack_total != 3'd0) bytes_left = 8'd1;
                  enter_phase(i2crm_pkg::PH_RX_BITS);
                end
                i2crm_pkg::PH_DW_ACK: begin
                  if (nack_total != 3'd0 || bytes_left <= 8'd1) begin
                    enter_phase(i2crm_pkg::PH_STOP);
                  end else begin
                    bytes_left--;
                    enter_phase(i2crm_pkg::PH_DW_BITS);
                  end
                end
                default: enter_phase(i2crm_pkg::PH_STOP);
              endcase
            end
          end
          i2crm_pkg::PH_RX_BITS: begin
            sda_rel = 1'b1;
            if (sub_tick == 2'd0) begin
              scl_pin  = 1'b1;
              sub_tick = 2'd1;
            end else if (sub_tick == 2'd1) begin
              shreg = {shreg[6:0], r.sda_sample};
              if (bit_idx == 3'd7) begin
                res.read_valid = 1'b1;
                res.read_byte  = shreg;
                res.read_last  = (bytes_left <= 8'd1);
              end
              sub_tick = 2'd2;
            end else begin
              scl_pin  = 1'b0;
              sub_tick = 2'd0;
              if (bit_idx == 3'd7) begin
                bit_idx   = 3'd0;
                bus_phase = i2crm_pkg::PH_RX_ACK;
              end else begin
                bit_idx++;
              end
            end
          end
          i2crm_pkg::PH_RX_ACK: begin
            sda_rel = 1'b0;
            sda_pin = (bytes_left <= 8'd1);
            if (sub_tick == 2'd0) begin
              scl_pin  = 1'b1;
              sub_tick = 2'd1;
            end else begin
              scl_pin   = 1'b0;
              sda_shown = sda_pin;
              if (bytes_left <= 8'd1) begin
                enter_phase(i2crm_pkg::PH_STOP);
              end else begin
                bytes_left--;
                enter_phase(i2crm_pkg::PH_RX_BITS);
              end
              sda_pin = 1'b0;
            end
          end
          default: begin
            sda_rel = 1'b0;
            if (sub_tick == 2'd0) begin
              sda_pin  = 1'b0;
              sub_tick = 2'd1;
            end else if (sub_tick == 2'd1) begin
              scl_pin  = 1'b1;
              sub_tick = 2'd2;
            end else begin
              sda_pin      = 1'b1;
              res.done_res = 1'b1;
              enter_phase(i2crm_pkg::PH_IDLE);
            end
          end
        endcase
        // Moving on to the next read byte, the ACK level stays on SDA
        if (!(bus_phase == i2crm_pkg::PH_RX_BITS && sub_tick == 2'd0 && bit_idx == 3'd0 &&
              !sda_pin && !sda_rel))
          sda_shown = sda_pin;
        res.scl_level    = scl_pin;
        res.sda_level    = sda_shown;
        res.sda_released = sda_rel;
        res.nack_count   = nack_total;
      end
      default: ;
    endcase
  endtask

  // Offer one request, hold it until taken, then book its expected result
  task automatic send_request(input req_t r, input bit typed,
                              input i2crm_pkg::result_t want);
    i2crm_pkg::result_t predicted;
    bit                 has_res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
    @(negedge clk);
    in_chan.valid            = 1'b1;
    in_chan.kind             = r.kind;
    in_chan.sda_sample       = r.sda_sample;
    in_chan.operation        = r.operation;
    in_chan.wide_register    = r.wide_register;
    in_chan.register_address = r.register_address;
    in_chan.byte_count       = r.byte_count;
    in_chan.data_byte        = r.data_byte;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    step_bus_master(r, has_res, predicted);
    if (has_res) results_due.push_back(typed ? want : predicted);
    accepted_requests++;
  endtask

  function automatic req_t random_request();
    req_t r;
    r.kind             = 2'($urandom_range(0, 3));
    r.sda_sample       = 1'($urandom_range(0, 1));
    r.operation        = 2'($urandom_range(0, 3));
    r.wide_register    = 1'($urandom_range(0, 1));
    r.register_address = 16'($urandom);
    r.byte_count       = 8'($urandom);
    r.data_byte        = 8'($urandom);
    return r;
  endfunction

  // Change the target address with the bus idle and nothing in flight
  task automatic write_slave_address(input logic [7:0] addr);
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = addr;
    @(negedge clk);
    cfg_we      = 1'b0;
    bus_address = addr;
  endtask

  // One well-formed transaction with random content, salted with ignored
  // requests, early or replacing write bytes and stalls for a missing byte.
  task automatic run_transaction();
    req_t r;
    int   nack_pct;
    int   fetch_pct;
    if ($urandom_range(0, 4) == 0) begin
      r      = random_request();
      r.kind = i2crm_pkg::KIND_DATA;
      send_request(r, 1'b0, NO_CHECK);
    end
    r      = random_request();
    r.kind = i2crm_pkg::KIND_COMMAND;
    if ($urandom_range(0, 19) == 0) begin
      r.operation = OP_UNUSED;
      send_request(r, 1'b0, NO_CHECK);
    end
    r.operation = 2'($urandom_range(0, 2));
    // Keep counts short; the rare large one is NACKed so it ends quickly
    if ($urandom_range(0, 29) == 0) r.byte_count = 8'($urandom_range(128, 255));
    else r.byte_count = 8'($urandom_range(0, 4));
    if (r.byte_count >= 8'd128) nack_pct = 100;
    else nack_pct = ($urandom_range(0, 3) == 0) ? 25 : 0;
    send_request(r, 1'b0, NO_CHECK);
    while (bus_phase != i2crm_pkg::PH_IDLE) begin
      r = random_request();
      fetch_pct = (sub_tick == 2'd0 && bit_idx == 3'd0) ? 70 : 5;
      if ($urandom_range(0, 29) == 0) begin
        // Noise: a command while busy, or the unused kind
        r.kind = $urandom_range(0, 1) ? i2crm_pkg::KIND_COMMAND : KIND_UNUSED;
      end else if (bus_phase == i2crm_pkg::PH_DW_BITS && !write_byte_slot[8] &&
                   $urandom_range(0, 99) < fetch_pct) begin
        r.kind = i2crm_pkg::KIND_DATA;
      end else begin
        r.kind = i2crm_pkg::KIND_TICK;
        if (bus_phase inside {i2crm_pkg::PH_AW_ACK, i2crm_pkg::PH_RH_ACK,
                              i2crm_pkg::PH_RL_ACK, i2crm_pkg::PH_AR_ACK,
                              i2crm_pkg::PH_DW_ACK, i2crm_pkg::PH_PR_ACK})
          r.sda_sample = ($urandom_range(0, 99) < nack_pct);
      end
      send_request(r, 1'b0, NO_CHECK);
    end
    repeat ($urandom_range(0, 2)) begin
      r      = random_request();
      r.kind = i2crm_pkg::KIND_TICK;
      send_request(r, 1'b0, NO_CHECK);
    end
  endtask

  // Result side: stall at random, or hold off for a counted stretch
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_chan.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_chan.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Check each taken result against the oldest expectation, field by field
  always @(posedge clk) begin
    i2crm_pkg::result_t got;
    i2crm_pkg::result_t exp;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.scl_level, out_chan.sda_level, out_chan.sda_released,
              out_chan.read_valid, out_chan.read_byte, out_chan.read_last,
              out_chan.write_wanted, out_chan.done_res, out_chan.nack_count};
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %p", got));
      end else begin
        exp = results_due.pop_front();
        if (got.scl_level !== exp.scl_level)
          report_mismatch($sformatf("scl_level %b, want %b", got.scl_level, exp.scl_level));
        if (got.sda_level !== exp.sda_level)
          report_mismatch($sformatf("sda_level %b, want %b", got.sda_level, exp.sda_level));
        if (got.sda_released !== exp.sda_released)
          report_mismatch($sformatf("sda_released %b, want %b",
                                    got.sda_released, exp.sda_released));
        if (got.read_valid !== exp.read_valid)
          report_mismatch($sformatf("read_valid %b, want %b", got.read_valid, exp.read_valid));
        if (got.read_byte !== exp.read_byte)
          report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, exp.read_byte));
        if (got.read_last !== exp.read_last)
          report_mismatch($sformatf("read_last %b, want %b", got.read_last, exp.read_last));
        if (got.write_wanted !== exp.write_wanted)
          report_mismatch($sformatf("write_wanted %b, want %b",
                                    got.write_wanted, exp.write_wanted));
        if (got.done_res !== exp.done_res)
          report_mismatch($sformatf("done_res %b, want %b", got.done_res, exp.done_res));
        if (got.nack_count !== exp.nack_count)
          report_mismatch($sformatf("nack_count %0d, want %0d", got.nack_count, exp.nack_count));
      end
      results_checked++;
    end
  end

  // Abandon the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        report_mismatch($sformatf("no transfer for %0d cycles", quiet_cycles));
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    script_row_t row;
    req_t        r;
    int          n;
    int          phase_end;

    // Known levels everywhere before the first edge
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = 8'h00;
    in_chan.valid            = 1'b0;
    in_chan.kind             = i2crm_pkg::KIND_TICK;
    in_chan.sda_sample       = 1'b0;
    in_chan.operation        = i2crm_pkg::OP_PROBE;
    in_chan.wide_register    = 1'b0;
    in_chan.register_address = 16'h0000;
    in_chan.byte_count       = 8'h00;
    in_chan.data_byte        = 8'h00;
    out_chan.ready           = 1'b0;
    sender_idle_pct          = 0;
    receiver_stall_pct       = 0;
    hold_cycles              = 0;
    quiet_cycles             = 0;
    accepted_requests        = 0;
    results_checked          = 0;
    mismatches               = 0;

    // Model state after reset: bus idle, both lines high and driven
    bus_address     = i2crm_pkg::SLAVE_ADDR_RESET;
    bus_phase       = i2crm_pkg::PH_IDLE;
    sub_tick        = 2'd0;
    bit_idx         = 3'd0;
    shreg           = 8'h00;
    bytes_left      = 8'h00;
    saved_reg       = 16'h0000;
    saved_op        = i2crm_pkg::OP_PROBE;
    saved_wide      = 1'b0;
    write_byte_slot = '0;
    nack_total      = 3'd0;
    scl_pin         = 1'b1;
    sda_pin         = 1'b1;
    sda_rel         = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the script; tick rows repeat a count or until the bus is idle
    foreach (script[i]) begin
      row = script[i];
      n   = 0;
      do begin
        r.kind             = row.kind;
        r.sda_sample       = (row.sda_mode == SDA_RANDOM) ? 1'($urandom_range(0, 1))
                                                          : row.sda_mode[0];
        r.operation        = row.operation;
        r.wide_register    = row.wide;
        r.register_address = row.reg_addr;
        r.byte_count       = row.count;
        r.data_byte        = row.data;
        send_request(r, row.typed, row.want);
        n++;
      end while ((row.reps == UNTIL_IDLE) ? (bus_phase != i2crm_pkg::PH_IDLE)
                                          : (n < row.reps));
    end

    // Random phases, each with its own address and idle/stall pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          write_slave_address(8'hff);
          // Hold the result side off while requests keep coming
          hold_cycles = HOLD_OFF;
        end
        1: begin
          sender_idle_pct    = 60;
          receiver_stall_pct = 0;
          write_slave_address(8'h00);
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 60;
          write_slave_address(8'($urandom_range(0, 255)));
        end
        default: begin
          sender_idle_pct    = 6;
          receiver_stall_pct = 6;
          write_slave_address(8'($urandom_range(0, 255)));
        end
      endcase
      phase_end = accepted_requests + PHASE_ITEMS;
      while (accepted_requests < phase_end) run_transaction();
    end

    // Drop the request side and drain what is still owed
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
